// ----- rtl/pti_pkg.sv -----
package pti_pkg;

	// Default pool size and fan-out
	localparam int NODES_DEF    = 4096;
	localparam int ALPHABET_DEF = 26;

	// Operation codes as they arrive on the first letter of a word
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_PREFIX = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	// One input word: a single letter of a key
	typedef struct packed {
		logic [1:0] op;
		logic [4:0] letter;
		logic       last;
	} item_t;

	// One result word, one per key
	typedef struct packed {
		logic found;
		logic out_of_space;
	} result_t;

	// Controller states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOOK  = 4'b0010,
		ST_ALLOC = 4'b0100,
		ST_ENDRD = 4'b1000
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic latch;
		logic follow;
		logic set_lost;
		logic link;
		logic alloc;
		logic mark_end;
		logic rd_child;
		logic emit;
		logic found;
		logic oos;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic skip;
		logic in_last;
		op_t  op;
		logic lost;
		logic present;
		logic full;
		logic last_q;
		logic end_bit;
	} sts_t;

endpackage

// ----- rtl/prefix_tree_insert_lookup.sv -----
// Prefix tree of NODES nodes with ALPHABET children each; node 0 is the root.
// Keys arrive one letter per word on item, taken when start is high and busy
// is low; the operation is read from the first letter of each key. A letter
// that follows an existing child is accepted, then looked up in the
// registered node-row and child-index memory reads, as is a letter whose
// child is missing in a search or in a full pool; a letter that allocates a
// node then adds an allocation step, as the parent row and the new node's
// clear share the single write port of the node memory; the last letter of
// an insert or exact search that follows an existing child also adds a step
// that reads the end mark of the node reached; a last letter out of range
// in an insert or exact search that has not failed is accepted, then reads
// the end mark of the current node; any other letter out of range, or any
// letter after a key has failed, is handled when it is accepted.
// Exactly one result word per key appears on result with done high for a
// single cycle, in the cycle after the key's final step; it cannot be held off
// and must be taken then. No clearing pass runs after reset: the block is
// ready at once.
module prefix_tree_insert_lookup #(
	parameter int NODES    = pti_pkg::NODES_DEF,
	parameter int ALPHABET = pti_pkg::ALPHABET_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pti_pkg::item_t   item,
	output logic             done,
	output pti_pkg::result_t result
);

	pti_pkg::cmd_t cmd;
	pti_pkg::sts_t sts;

	pti_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	pti_dp #(
		.NODES    (NODES),
		.ALPHABET (ALPHABET)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

endmodule

// ----- rtl/pti_ram.sv -----
module pti_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/pti_ctrl.sv -----
module pti_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pti_pkg::sts_t sts,
	output pti_pkg::cmd_t cmd
);

	pti_pkg::state_t state_q, state_d;

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pti_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != pti_pkg::ST_IDLE);

	// Decode the next step from datapath status
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			pti_pkg::ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					if (sts.skip) begin
						// letter takes no lookup: finish the key if it ends here
						if (sts.in_last) begin
							if (sts.lost || sts.op == pti_pkg::OP_PREFIX) begin
								cmd.emit  = 1'b1;
								cmd.found = !sts.lost;
								cmd.oos   = sts.lost && sts.op == pti_pkg::OP_INSERT;
							end else begin
								state_d = pti_pkg::ST_ENDRD;
							end
						end
					end else begin
						state_d = pti_pkg::ST_LOOK;
					end
				end
			end
			pti_pkg::ST_LOOK: begin
				state_d = pti_pkg::ST_IDLE;
				if (sts.present) begin
					cmd.follow = 1'b1;
					if (sts.last_q) begin
						if (sts.op == pti_pkg::OP_PREFIX) begin
							cmd.emit  = 1'b1;
							cmd.found = 1'b1;
						end else begin
							cmd.rd_child = 1'b1;
							state_d      = pti_pkg::ST_ENDRD;
						end
					end
				end else if (sts.op != pti_pkg::OP_INSERT || sts.full) begin
					// drop the rest of the key
					cmd.set_lost = 1'b1;
					if (sts.last_q) begin
						cmd.emit = 1'b1;
						cmd.oos  = (sts.op == pti_pkg::OP_INSERT);
					end
				end else begin
					cmd.link = 1'b1;
					state_d  = pti_pkg::ST_ALLOC;
				end
			end
			pti_pkg::ST_ALLOC: begin
				cmd.alloc = 1'b1;
				if (sts.last_q) begin
					cmd.emit  = 1'b1;
					cmd.found = 1'b1;
				end
				state_d = pti_pkg::ST_IDLE;
			end
			pti_pkg::ST_ENDRD: begin
				cmd.emit = 1'b1;
				if (sts.op == pti_pkg::OP_INSERT) begin
					cmd.mark_end = 1'b1;
					cmd.found    = 1'b1;
				end else begin
					cmd.found = sts.end_bit;
				end
				state_d = pti_pkg::ST_IDLE;
			end
			default: begin
				state_d = pti_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/pti_dp.sv -----
module pti_dp #(
	parameter int NODES    = pti_pkg::NODES_DEF,
	parameter int ALPHABET = pti_pkg::ALPHABET_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  pti_pkg::item_t   item,
	input  pti_pkg::cmd_t    cmd,
	output pti_pkg::sts_t    sts,
	output logic             done,
	output pti_pkg::result_t result
);

	localparam int NW = $clog2(NODES);
	localparam int CW = $clog2(NODES + 1);
	localparam int LW = $clog2(ALPHABET);
	localparam int SW = $clog2(NODES * ALPHABET);
	localparam int RW = ALPHABET + 1;

	// Key walk state
	logic [NW-1:0]    cursor_q;
	logic [CW-1:0]    nodes_used_q;
	logic             path_lost_q;
	logic             in_word_q;
	pti_pkg::op_t     word_op_q;
	logic             root_written_q;
	logic             done_q;

	// Per-letter payload
	logic [LW-1:0]    letter_q;
	logic             last_q;
	logic [SW-1:0]    slot_q;
	logic [NW-1:0]    node_raddr_q;
	pti_pkg::result_t result_q;

	pti_pkg::op_t     eff_op;
	logic [NW-1:0]    eff_cur;
	logic             eff_lost;
	logic             letter_ok;
	logic [SW-1:0]    walk_slot;
	logic [NW-1:0]    node_raddr;
	logic [RW-1:0]    node_rdata;
	logic [RW-1:0]    row_eff;
	logic             node_we;
	logic [NW-1:0]    node_waddr;
	logic [RW-1:0]    node_wdata;
	logic [NW-1:0]    child_rdata;

	// Take the operation and start from the root on a key's first letter
	always_comb begin
		if (in_word_q) begin
			eff_op = word_op_q;
		end else if (item.op == pti_pkg::OP_RSVD) begin
			eff_op = pti_pkg::OP_SEARCH;
		end else begin
			eff_op = pti_pkg::op_t'(item.op);
		end
	end

	assign eff_cur   = in_word_q ? cursor_q : '0;
	assign eff_lost  = in_word_q && path_lost_q;
	assign letter_ok = (32'(item.letter) < 32'(ALPHABET));
	assign walk_slot = SW'(eff_cur) * SW'(ALPHABET) + SW'(item.letter);

	// Read the node row at the cursor, or at the child just found
	assign node_raddr = cmd.rd_child ? child_rdata : eff_cur;

	// Root row reads as clear until first written
	assign row_eff = (node_raddr_q == '0 && !root_written_q) ? '0 : node_rdata;

	// Node row writes: link a child, clear a new node, set an end mark
	always_comb begin
		node_we    = cmd.link || cmd.alloc || cmd.mark_end;
		node_waddr = cursor_q;
		node_wdata = row_eff;
		if (cmd.alloc) begin
			node_waddr = nodes_used_q[NW-1:0];
			node_wdata = {last_q, {ALPHABET{1'b0}}};
		end else if (cmd.link) begin
			node_wdata = row_eff | (RW'(1) << letter_q);
		end else begin
			node_wdata = {1'b1, row_eff[ALPHABET-1:0]};
		end
	end

	pti_ram #(
		.WIDTH (RW),
		.DEPTH (NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	pti_ram #(
		.WIDTH (NW),
		.DEPTH (NODES * ALPHABET)
	) u_child_ram (
		.clk   (clk),
		.we    (cmd.link),
		.waddr (slot_q),
		.wdata (nodes_used_q[NW-1:0]),
		.raddr (walk_slot),
		.rdata (child_rdata)
	);

	// Hold the walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q       <= '0;
			nodes_used_q   <= CW'(1);
			path_lost_q    <= 1'b0;
			in_word_q      <= 1'b0;
			word_op_q      <= pti_pkg::OP_INSERT;
			root_written_q <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			if (cmd.emit) begin
				// close the key
				in_word_q   <= 1'b0;
				cursor_q    <= '0;
				path_lost_q <= 1'b0;
			end else if (cmd.latch && !in_word_q) begin
				word_op_q   <= eff_op;
				cursor_q    <= '0;
				path_lost_q <= 1'b0;
				in_word_q   <= 1'b1;
			end else if (cmd.follow) begin
				cursor_q <= child_rdata;
			end else if (cmd.alloc) begin
				cursor_q <= nodes_used_q[NW-1:0];
			end else if (cmd.set_lost) begin
				path_lost_q <= 1'b1;
			end
			if (cmd.alloc) begin
				nodes_used_q <= nodes_used_q + CW'(1);
			end
			if (node_we && node_waddr == '0) begin
				root_written_q <= 1'b1;
			end
			done_q <= cmd.emit;
		end
	end

	// Capture the letter and the result word
	always_ff @(posedge clk) begin
		node_raddr_q <= node_raddr;
		if (cmd.latch) begin
			letter_q <= LW'(item.letter);
			last_q   <= item.last;
			slot_q   <= walk_slot;
		end
		if (cmd.emit) begin
			result_q.found        <= cmd.found;
			result_q.out_of_space <= cmd.oos;
		end
	end

	assign sts.skip    = eff_lost || !letter_ok;
	assign sts.in_last = item.last;
	assign sts.op      = eff_op;
	assign sts.lost    = eff_lost;
	assign sts.present = row_eff[letter_q];
	assign sts.full    = (nodes_used_q == CW'(NODES));
	assign sts.last_q  = last_q;
	assign sts.end_bit = row_eff[ALPHABET];

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- rtl/pti_checker.sv -----
module pti_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input pti_pkg::item_t   item,
	input logic             done,
	input pti_pkg::result_t result
);

	// A result word never reports both success and a full pool
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.found && result.out_of_space))
		else $error("result word with found and out_of_space both set");

	// A result word follows either an accepted word or a busy step
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start) || $past(busy)))
		else $error("result word with no work behind it");

	// An accepted letter that does not end a key yields no result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !item.last) |=> !done)
		else $error("result word after a letter that is not last");

	// Work on one letter returns the block to idle after LOOK and at most one of ALLOC or ENDRD
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> ##[1:2] !busy)
		else $error("busy held for too long");

endmodule

bind prefix_tree_insert_lookup pti_checker u_pti_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);
